@@ rtl/abmr_pkg.sv @@
// abmr_pkg: shared types and constants of the bus memory responder
// used by the core, abmr_eval and abmr_checker; no dependencies of its own
`default_nettype none

package abmr_pkg;

    // default address width of the internal ram
    localparam int ADDR_BITS_DEF = 16;

    // request commands
    localparam logic [1:0] CMD_PINS   = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_ADDR   = 2'd2;
    localparam logic [1:0] CMD_SAMPLE = 2'd3;

    // pin positions in the pin word
    localparam int PIN_WR  = 0;
    localparam int PIN_RD  = 1;
    localparam int PIN_CS  = 2;
    localparam int PIN_CLK = 4;

    // strobes and reset pin high, clock low
    localparam logic [4:0] PINS_RESET = 5'h0F;

    // fault codes
    localparam logic [2:0] FAULT_OK        = 3'd0;
    localparam logic [2:0] FAULT_WR_RD_LOW = 3'd1;
    localparam logic [2:0] FAULT_RD_WR_LOW = 3'd2;
    localparam logic [2:0] FAULT_BOTH_LOW  = 3'd3;
    localparam logic [2:0] FAULT_RISE_WR   = 3'd4;
    localparam logic [2:0] FAULT_MOVE_WR   = 3'd5;
    localparam logic [2:0] FAULT_MOVE_CS   = 3'd6;

    // architectural state without the address registers
    typedef struct packed {
        logic [4:0] pins_now;
        logic [4:0] pins_before;
        logic [7:0] data_bus;
        logic [2:0] fault;
    } t_core_state;

    // ram control from the event logic
    typedef struct packed {
        logic ram_wr;
        logic ram_rd;
    } t_ram_ctl;

endpackage

`default_nettype wire

@@ rtl/async_bus_memory_responder_core.sv @@
// async_bus_memory_responder_core: top level of the bus memory responder
// depends on abmr_pkg, abmr_eval and abmr_ram
`default_nettype none

// Memory side of a parallel bus with active-low select, read and write
// strobes and a clock pin. One request is taken per clock cycle when
// o_in_stall is low; its result goes from the input register through the
// event logic into the state and result registers, and a ram read lands in
// the bus data through the ram's registered read port in that same step.
// The ram port is used at most once per request, which sets the rate. After
// reset a clearing pass writes zero to each of the 2^ADDR_BITS ram bytes
// (65536 at the default width), one per cycle; requests are stalled until
// it ends. Once a fault code is recorded it holds and every later request
// leaves the state unchanged.
module async_bus_memory_responder_core #(
    parameter int ADDR_BITS = abmr_pkg::ADDR_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [15:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_bus_data,
    output logic             o_write_done,
    output logic [15:0]      o_write_address,
    output logic [2:0]       o_fault_code
);

    // input register
    logic                  r_in_valid;
    logic [1:0]            r_cmd;
    logic [15:0]           r_value;

    // architectural state
    abmr_pkg::t_core_state r_state;
    logic [ADDR_BITS-1:0]  r_addr_in;
    logic [ADDR_BITS-1:0]  r_addr_latched;
    logic                  r_rd_fwd;

    // result register
    logic                  r_out_valid;
    logic                  r_write_done;
    logic [15:0]           r_write_address;

    // clearing pass
    logic                  r_clr_busy;
    logic [ADDR_BITS-1:0]  r_clr_cnt;

    abmr_pkg::t_core_state cur_state;
    abmr_pkg::t_core_state n_state;
    logic [ADDR_BITS-1:0]  n_addr_in;
    logic [ADDR_BITS-1:0]  n_addr_latched;
    abmr_pkg::t_ram_ctl    ctl;
    logic [7:0]            ram_q;
    logic                  out_free;
    logic                  advance;
    logic                  in_accept;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [7:0]            ram_wr_data;

    // bus data comes from the ram after a read
    always_comb begin
        cur_state = r_state;
        if (r_rd_fwd) begin
            cur_state.data_bus = ram_q;
        end
    end

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_clr_busy || (r_in_valid && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    // event logic
    abmr_eval #(
        .ADDR_BITS (ADDR_BITS)
    ) u_eval (
        .i_cmd          (r_cmd),
        .i_value        (r_value),
        .i_state        (cur_state),
        .i_addr_in      (r_addr_in),
        .i_addr_latched (r_addr_latched),
        .o_state        (n_state),
        .o_addr_in      (n_addr_in),
        .o_addr_latched (n_addr_latched),
        .o_ctl          (ctl)
    );

    // ram port: clearing pass or one access per request
    assign ram_wr_en   = r_clr_busy || (advance && ctl.ram_wr);
    assign ram_rd_en   = advance && ctl.ram_rd;
    assign ram_addr    = r_clr_busy ? r_clr_cnt : n_addr_latched;
    assign ram_wr_data = r_clr_busy ? 8'h00 : n_state.data_bus;

    abmr_ram #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_rd_en   (ram_rd_en),
        .i_addr    (ram_addr),
        .i_wr_data (ram_wr_data),
        .o_rd_data (ram_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_clr_busy          <= 1'b1;
            r_clr_cnt           <= '0;
            r_rd_fwd            <= 1'b0;
            r_state.pins_now    <= abmr_pkg::PINS_RESET;
            r_state.pins_before <= abmr_pkg::PINS_RESET;
            r_state.data_bus    <= 8'h00;
            r_state.fault       <= abmr_pkg::FAULT_OK;
            r_addr_in           <= '0;
            r_addr_latched      <= '0;
        end else begin
            // clearing pass
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end

            // input register occupancy
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            // result register occupancy
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end

            // state update
            if (advance) begin
                r_state        <= n_state;
                r_addr_in      <= n_addr_in;
                r_addr_latched <= n_addr_latched;
                r_rd_fwd       <= ctl.ram_rd;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
        if (advance) begin
            r_write_done    <= ctl.ram_wr;
            r_write_address <= ctl.ram_wr ? 16'(n_addr_latched) : 16'h0000;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bus_data      = cur_state.data_bus;
    assign o_write_done    = r_write_done;
    assign o_write_address = r_write_address;
    assign o_fault_code    = r_state.fault;

endmodule

`default_nettype wire

@@ rtl/abmr_ram.sv @@
// abmr_ram: byte-wide single-port ram with registered read data
// depends on nothing but its parameter
`default_nettype none

module abmr_ram #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic                 i_rd_en,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic [7:0]           i_wr_data,
    output logic      [7:0]           o_rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // one write, one read or both per cycle, at the same address
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/abmr_eval.sv @@
// abmr_eval: next-state logic for one bus request (pins, edges, faults)
// depends on abmr_pkg
`default_nettype none

module abmr_eval #(
    parameter int ADDR_BITS = abmr_pkg::ADDR_BITS_DEF
) (
    input  wire logic [1:0]            i_cmd,
    input  wire logic [15:0]           i_value,
    input  wire abmr_pkg::t_core_state i_state,
    input  wire logic [ADDR_BITS-1:0]  i_addr_in,
    input  wire logic [ADDR_BITS-1:0]  i_addr_latched,
    output abmr_pkg::t_core_state      o_state,
    output logic      [ADDR_BITS-1:0]  o_addr_in,
    output logic      [ADDR_BITS-1:0]  o_addr_latched,
    output abmr_pkg::t_ram_ctl         o_ctl
);

    always_comb begin
        abmr_pkg::t_core_state st;
        logic [ADDR_BITS-1:0]  ain;
        logic [ADDR_BITS-1:0]  alat;
        logic [4:0]            fell;
        logic [4:0]            rose;
        logic                  wr;
        logic                  rd;
        logic                  cs;
        logic                  moved;

        st            = i_state;
        ain           = i_addr_in;
        alat          = i_addr_latched;
        o_ctl.ram_wr  = 1'b0;
        o_ctl.ram_rd  = 1'b0;
        fell          = '0;
        rose          = '0;
        wr            = 1'b0;
        rd            = 1'b0;
        cs            = 1'b0;
        moved         = 1'b0;

        // halted once a fault is recorded
        if (i_state.fault == abmr_pkg::FAULT_OK) begin
            // apply the request
            case (i_cmd)
                abmr_pkg::CMD_PINS: begin
                    st.pins_before = i_state.pins_now;
                    st.pins_now    = i_value[4:0];
                end
                abmr_pkg::CMD_DATA: begin
                    st.data_bus = i_value[7:0];
                end
                abmr_pkg::CMD_ADDR: begin
                    ain = i_value[ADDR_BITS-1:0];
                end
                default: begin
                end
            endcase

            // edges between the last two pin settings
            fell = st.pins_before & ~st.pins_now;
            rose = ~st.pins_before & st.pins_now;
            wr   = !st.pins_now[abmr_pkg::PIN_WR];
            rd   = !st.pins_now[abmr_pkg::PIN_RD];
            cs   = !st.pins_now[abmr_pkg::PIN_CS];

            // deselect clears the bus, select latches the address
            if (rose[abmr_pkg::PIN_CS]) begin
                st.data_bus = 8'h00;
            end
            if (fell[abmr_pkg::PIN_CS]) begin
                alat = ain;
            end

            if (cs) begin
                // ram access
                o_ctl.ram_wr = wr && !rd;
                o_ctl.ram_rd = !wr && rd && fell[abmr_pkg::PIN_CLK];

                // fault checks in priority order
                moved = ain != alat;
                if (rd && fell[abmr_pkg::PIN_WR] && !fell[abmr_pkg::PIN_RD]) begin
                    st.fault = abmr_pkg::FAULT_WR_RD_LOW;
                end else if (wr && fell[abmr_pkg::PIN_RD] && !fell[abmr_pkg::PIN_WR]) begin
                    st.fault = abmr_pkg::FAULT_RD_WR_LOW;
                end else if (wr && rd) begin
                    st.fault = abmr_pkg::FAULT_BOTH_LOW;
                end else if (wr && (rose[abmr_pkg::PIN_CS] || rose[abmr_pkg::PIN_CLK])) begin
                    st.fault = abmr_pkg::FAULT_RISE_WR;
                end else if (moved && wr) begin
                    st.fault = abmr_pkg::FAULT_MOVE_WR;
                end else if (moved) begin
                    st.fault = abmr_pkg::FAULT_MOVE_CS;
                end
            end
        end

        o_state        = st;
        o_addr_in      = ain;
        o_addr_latched = alat;
    end

endmodule

`default_nettype wire

@@ rtl/abmr_checker.sv @@
// abmr_checker: port-level checks on the bus memory responder
// bound to async_bus_memory_responder_core; fault codes from abmr_pkg
`default_nettype none

module abmr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_bus_data,
    input wire logic        o_write_done,
    input wire logic [15:0] o_write_address,
    input wire logic [2:0]  o_fault_code
);

    // a stalled result holds its payload
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_bus_data) && $stable(o_write_done)
             && $stable(o_write_address) && $stable(o_fault_code)))
        else $error("result changed while stalled");

    // a recorded fault never clears or changes
    a_fault_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_fault_code != abmr_pkg::FAULT_OK) |=> (o_fault_code == $past(o_fault_code)))
        else $error("fault code changed after being set");

    // no write reported means no write address
    a_addr_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_done) |-> (o_write_address == 16'h0000))
        else $error("write address without a write");

    // fault code stays within the defined set
    a_fault_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fault_code <= abmr_pkg::FAULT_MOVE_CS)
        else $error("undefined fault code");

endmodule

bind async_bus_memory_responder_core abmr_checker u_abmr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_bus_data      (o_bus_data),
    .o_write_done    (o_write_done),
    .o_write_address (o_write_address),
    .o_fault_code    (o_fault_code)
);

`default_nettype wire
